// ===== rtl/rrsm_pkg.sv =====
`default_nettype none
package rrsm_pkg;

    localparam int MAX_PROCS  = 64;
    localparam int TIME_WIDTH = 16;
    localparam int IDX_W      = $clog2(MAX_PROCS);
    localparam int CNT_W      = $clog2(MAX_PROCS + 1);
    localparam int SIM_W      = 32;
    localparam int SUM_W      = 32;
    localparam int Q_W        = 16;
    localparam logic [Q_W-1:0] QUANTUM_RESET = Q_W'(10);

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_SCAN_RD,
        S_SCAN_CK,
        S_DECIDE,
        S_FETCH,
        S_EXEC,
        S_FINISH,
        S_REQUEUE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic init;
        logic scan_ck;
        logic jump;
        logic pop;
        logic fetch;
        logic exec;
        logic finish;
        logic requeue;
        logic clear;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_last;
        logic fifo_empty;
        logic all_admitted;
        logic preempt;
    } t_dp_sts;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/rrsm_ram.sv =====
`default_nettype none
module rrsm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/rrsm_ctrl.sv =====
`default_nettype none
module rrsm_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire logic            i_last,
    input  rrsm_pkg::t_dp_sts    i_sts,
    output rrsm_pkg::t_dp_cmd    o_cmd,
    output logic                 o_busy,
    output logic                 o_valid
);
    rrsm_pkg::t_state r_state, n_state;
    logic r_requeue, n_requeue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rrsm_pkg::S_IDLE;
            r_requeue <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_requeue <= n_requeue;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_requeue = r_requeue;
        o_cmd     = '0;
        o_busy    = (r_state != rrsm_pkg::S_IDLE);
        o_valid   = 1'b0;
        unique case (r_state)
            rrsm_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_last) n_state = rrsm_pkg::S_INIT;
                end
            end
            rrsm_pkg::S_INIT: begin
                o_cmd.init = 1'b1;
                n_requeue  = 1'b0;
                n_state    = rrsm_pkg::S_SCAN_RD;
            end
            rrsm_pkg::S_SCAN_RD: n_state = rrsm_pkg::S_SCAN_CK;
            rrsm_pkg::S_SCAN_CK: begin
                o_cmd.scan_ck = 1'b1;
                if (!i_sts.scan_last) n_state = rrsm_pkg::S_SCAN_RD;
                else if (r_requeue)   n_state = rrsm_pkg::S_REQUEUE;
                else                  n_state = rrsm_pkg::S_DECIDE;
            end
            rrsm_pkg::S_DECIDE: begin
                priority if (!i_sts.fifo_empty) begin
                    o_cmd.pop = 1'b1;
                    n_state   = rrsm_pkg::S_FETCH;
                end else if (i_sts.all_admitted) begin
                    n_state = rrsm_pkg::S_DONE;
                end else begin
                    // idle forward to the next arrival
                    o_cmd.jump = 1'b1;
                    n_requeue  = 1'b0;
                    n_state    = rrsm_pkg::S_SCAN_RD;
                end
            end
            rrsm_pkg::S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = rrsm_pkg::S_EXEC;
            end
            rrsm_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_sts.preempt) begin
                    n_requeue = 1'b1;
                    n_state   = rrsm_pkg::S_SCAN_RD;
                end else begin
                    n_state = rrsm_pkg::S_FINISH;
                end
            end
            rrsm_pkg::S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_requeue    = 1'b0;
                n_state      = rrsm_pkg::S_SCAN_RD;
            end
            rrsm_pkg::S_REQUEUE: begin
                o_cmd.requeue = 1'b1;
                n_state       = rrsm_pkg::S_DECIDE;
            end
            rrsm_pkg::S_DONE: begin
                o_valid     = 1'b1;
                o_cmd.clear = 1'b1;
                n_state     = rrsm_pkg::S_IDLE;
            end
            default: n_state = rrsm_pkg::S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ===== rtl/rrsm_dp.sv =====
`default_nettype none
module rrsm_dp (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_quantum_we,
    input  wire logic [rrsm_pkg::Q_W-1:0]            i_quantum,
    input  wire logic [rrsm_pkg::TIME_WIDTH-1:0]     i_arrival,
    input  wire logic [rrsm_pkg::TIME_WIDTH-1:0]     i_burst,
    input  rrsm_pkg::t_dp_cmd                        i_cmd,
    output rrsm_pkg::t_dp_sts                        o_sts,
    output logic [rrsm_pkg::SUM_W-1:0]               o_total_wait,
    output logic [rrsm_pkg::SUM_W-1:0]               o_total_response,
    output logic [rrsm_pkg::CNT_W-1:0]               o_process_count
);
    localparam int TW = rrsm_pkg::TIME_WIDTH;
    localparam int IW = rrsm_pkg::IDX_W;
    localparam int CW = rrsm_pkg::CNT_W;
    localparam int SW = rrsm_pkg::SIM_W;
    localparam int UW = rrsm_pkg::SUM_W;
    localparam int QW = rrsm_pkg::Q_W;

    logic [QW-1:0] r_quantum;
    logic [CW-1:0] r_count, r_admitted, r_fcnt;
    logic [IW-1:0] r_scan_idx, r_head, r_tail, r_cur;
    logic [SW-1:0] r_time;
    logic [TW-1:0] r_min;
    logic [TW:0]   r_arrbur;
    logic [UW-1:0] r_wait, r_resp;
    logic [rrsm_pkg::MAX_PROCS-1:0] r_queued, r_started;

    logic [TW-1:0] arr_q, bur_q, rem_q;
    logic [IW-1:0] fifo_q;
    logic [QW-1:0] q_eff;
    logic          room, hit, push;
    logic [TW-1:0] min_base;
    logic [IW-1:0] arr_raddr, rem_waddr;
    logic          rem_we;
    logic [TW-1:0] rem_wdata;

    assign q_eff     = (r_quantum == '0) ? QW'(1) : r_quantum;
    assign room      = (r_count < CW'(rrsm_pkg::MAX_PROCS));
    assign hit       = !r_queued[r_scan_idx] && (SW'(arr_q) <= r_time);
    assign push      = (i_cmd.scan_ck && hit) || i_cmd.requeue;
    assign min_base  = (r_scan_idx == '0) ? {TW{1'b1}} : r_min;
    assign arr_raddr = i_cmd.fetch ? fifo_q : r_scan_idx;
    assign rem_we    = (i_cmd.load && room) || (i_cmd.exec && o_sts.preempt);
    assign rem_waddr = i_cmd.load ? r_count[IW-1:0] : r_cur;
    assign rem_wdata = i_cmd.load ? i_burst : TW'(rem_q - TW'(q_eff));

    assign o_sts.scan_last    = ({1'b0, r_scan_idx} == r_count - CW'(1));
    assign o_sts.fifo_empty   = (r_fcnt == '0);
    assign o_sts.all_admitted = (r_admitted == r_count);
    assign o_sts.preempt      = (TW'(rem_q) > TW'(q_eff));

    assign o_total_wait     = r_wait;
    assign o_total_response = r_resp;
    assign o_process_count  = r_count;

    rrsm_ram #(.WIDTH(TW), .DEPTH(rrsm_pkg::MAX_PROCS)) u_arr (
        .i_clk, .i_we(i_cmd.load && room), .i_waddr(r_count[IW-1:0]),
        .i_wdata(i_arrival), .i_raddr(arr_raddr), .o_rdata(arr_q)
    );
    rrsm_ram #(.WIDTH(TW), .DEPTH(rrsm_pkg::MAX_PROCS)) u_bur (
        .i_clk, .i_we(i_cmd.load && room), .i_waddr(r_count[IW-1:0]),
        .i_wdata(i_burst), .i_raddr(fifo_q), .o_rdata(bur_q)
    );
    rrsm_ram #(.WIDTH(TW), .DEPTH(rrsm_pkg::MAX_PROCS)) u_rem (
        .i_clk, .i_we(rem_we), .i_waddr(rem_waddr),
        .i_wdata(rem_wdata), .i_raddr(fifo_q), .o_rdata(rem_q)
    );
    rrsm_ram #(.WIDTH(IW), .DEPTH(rrsm_pkg::MAX_PROCS)) u_fifo (
        .i_clk, .i_we(push), .i_waddr(r_tail),
        .i_wdata(i_cmd.requeue ? r_cur : r_scan_idx), .i_raddr(r_head), .o_rdata(fifo_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quantum <= rrsm_pkg::QUANTUM_RESET;
            r_count   <= '0;
            r_fcnt    <= '0;
            r_head    <= '0;
            r_tail    <= '0;
            r_scan_idx <= '0;
            r_admitted <= '0;
            r_queued  <= '0;
            r_started <= '0;
        end else begin
            if (i_quantum_we) r_quantum <= i_quantum;
            if (i_cmd.load && room) r_count <= r_count + CW'(1);
            if (i_cmd.clear) r_count <= '0;
            if (i_cmd.init) begin
                r_fcnt     <= '0;
                r_head     <= '0;
                r_tail     <= '0;
                r_scan_idx <= '0;
                r_admitted <= '0;
                r_queued   <= '0;
                r_started  <= '0;
            end
            if (i_cmd.scan_ck) begin
                r_scan_idx <= o_sts.scan_last ? '0 : r_scan_idx + IW'(1);
                if (hit) begin
                    r_queued[r_scan_idx] <= 1'b1;
                    r_admitted <= r_admitted + CW'(1);
                end
            end
            if (push) begin
                r_tail <= r_tail + IW'(1);
            end
            if (i_cmd.pop) begin
                r_head <= r_head + IW'(1);
            end
            if (push && !i_cmd.pop) r_fcnt <= r_fcnt + CW'(1);
            else if (i_cmd.pop && !push) r_fcnt <= r_fcnt - CW'(1);
            if (i_cmd.exec) r_started[r_cur] <= 1'b1;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_time <= '0;
            r_wait <= '0;
            r_resp <= '0;
        end
        if (i_cmd.scan_ck && !hit && !r_queued[r_scan_idx]) begin
            r_min <= (arr_q < min_base) ? arr_q : min_base;
        end else if (i_cmd.scan_ck) begin
            r_min <= min_base;
        end
        if (i_cmd.jump) r_time <= SW'(r_min);
        if (i_cmd.fetch) r_cur <= fifo_q;
        if (i_cmd.exec) begin
            r_arrbur <= {1'b0, arr_q} + {1'b0, bur_q};
            if (!r_started[r_cur]) begin
                r_resp <= rrsm_pkg::sat_add(r_resp, UW'(r_time - SW'(arr_q)));
            end
            if (o_sts.preempt) r_time <= r_time + SW'(q_eff);
            else               r_time <= r_time + SW'(rem_q);
        end
        if (i_cmd.finish) begin
            r_wait <= rrsm_pkg::sat_add(r_wait, UW'(r_time - SW'(r_arrbur)));
        end
    end
endmodule
`default_nettype wire

// ===== rtl/round_robin_schedule_metrics_core.sv =====
`default_nettype none
// Round-robin schedule metrics. Load process records (arrival, burst) one per
// clock while busy is low; records beyond 64 are dropped. The record with
// i_last high starts the round-robin run using the quantum register (reset 10,
// a zero quantum runs as 1). busy stays high for the whole run; when it ends,
// o_valid pulses for exactly one cycle with the saturating total wait, total
// response and process count, and the receiver cannot stall it, so capture
// the transaction on that cycle. Every admission point rescans all N stored
// records with one RAM read and one compare each, and each time slice is
// dispatched through the ready-queue RAM in the decide, fetch, execute and
// then finish or requeue states; an idle jump moves time to the next arrival.
// A run also holds setup, the first scan, the final queue check and the result.
// Write the quantum only while busy is low.
module round_robin_schedule_metrics_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [rrsm_pkg::TIME_WIDTH-1:0]     i_arrival,
    input  wire logic [rrsm_pkg::TIME_WIDTH-1:0]     i_burst,
    input  wire logic                                i_last,
    input  wire logic                                i_quantum_we,
    input  wire logic [rrsm_pkg::Q_W-1:0]            i_quantum,
    output logic                                     o_valid,
    output logic [rrsm_pkg::SUM_W-1:0]               o_total_wait,
    output logic [rrsm_pkg::SUM_W-1:0]               o_total_response,
    output logic [rrsm_pkg::CNT_W-1:0]               o_process_count
);
    rrsm_pkg::t_dp_cmd cmd;
    rrsm_pkg::t_dp_sts sts;

    // sequencer: load, admission scans, dispatch, completion
    rrsm_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_start(start), .i_last,
        .i_sts(sts), .o_cmd(cmd), .o_busy(busy), .o_valid
    );

    // stores, ready queue, simulated time and totals
    rrsm_dp u_dp (
        .i_clk, .i_rst_n, .i_quantum_we, .i_quantum, .i_arrival, .i_burst,
        .i_cmd(cmd), .o_sts(sts), .o_total_wait, .o_total_response,
        .o_process_count
    );
endmodule
`default_nettype wire

// ===== rtl/rrsm_checker.sv =====
`default_nettype none
module rrsm_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         start,
    input wire logic                         busy,
    input wire logic                         o_valid,
    input wire logic [rrsm_pkg::CNT_W-1:0]   o_process_count
);
    a_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe longer than one cycle");
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy) else $error("result outside a run");
    a_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !busy) else $error("busy held after result");
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy && !o_valid) else $error("not idle after reset");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_process_count != '0) else $error("empty batch reported");
endmodule

bind round_robin_schedule_metrics_core rrsm_checker u_rrsm_checker (.*);
`default_nettype wire
